@@ design/hec_pkg.sv @@
`timescale 1ns / 1ps

package hec_pkg;

    // Shared multiplier operand and accumulator widths
    localparam int MUL_W = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W = 98;
    localparam int SIG_W = 48;

    typedef logic signed [MUL_W-1:0] mul_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [SIG_W-1:0] sig_t;

    // Product alignment codes
    localparam logic [1:0] SH_0 = 2'd0;
    localparam logic [1:0] SH_24 = 2'd1;
    localparam logic [1:0] SH_48 = 2'd2;

    typedef struct packed {
        logic       issue;
        logic       clr;
        logic [1:0] sh;
    } mac_ctl_t;

    // One filter history entry: two past inputs and two past outputs
    typedef struct packed {
        sig_t x1;
        sig_t x2;
        sig_t y1;
        sig_t y2;
    } hist_t;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_VOLUME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2 = 3'd7;

    // Register reset values
    localparam logic [20:0] RST_INPUT_GAIN = 21'd65536;
    localparam logic [16:0] RST_MIX = 17'd65536;
    localparam logic [20:0] RST_OUTPUT_VOLUME = 21'd65536;
    localparam logic [3:0] RST_HARMONIC_ENABLE = 4'd1;
    localparam logic signed [31:0] RST_COEF_B0 = 32'sd1071735854;
    localparam logic signed [31:0] RST_COEF_B1 = -32'sd2143471708;
    localparam logic signed [31:0] RST_COEF_A1 = -32'sd2143467948;
    localparam logic signed [31:0] RST_COEF_A2 = 32'sd1069733546;

    localparam logic [16:0] MIX_ONE = 17'd65536;
    localparam acc_t SIG_MAX_A = (acc_t'(1) <<< (SIG_W - 1)) - acc_t'(1);
    localparam acc_t SIG_MIN_A = -(acc_t'(1) <<< (SIG_W - 1));
    localparam acc_t WET_LIM_A = acc_t'(1) <<< 24;

    // Harmonic gains
    localparam acc_t GAIN_H2 = acc_t'(2);
    localparam acc_t GAIN_H4 = acc_t'(8);
    localparam acc_t GAIN_H6 = acc_t'(16);
    localparam acc_t GAIN_H8 = acc_t'(24);

    // Round to nearest, ties upward, then shift right arithmetically
    function automatic acc_t rnd_asr(acc_t v, int unsigned n);
        return (v + (acc_t'(1) <<< (n - 1))) >>> n;
    endfunction

    // Saturate to the 48-bit signal range
    function automatic sig_t sat_sig(acc_t v);
        acc_t r;
        r = (v > SIG_MAX_A) ? SIG_MAX_A : ((v < SIG_MIN_A) ? SIG_MIN_A : v);
        return r[SIG_W-1:0];
    endfunction

    // Low 24 bits of a signal as a positive operand
    function automatic mul_t lo_op(sig_t v);
        return mul_t'({1'b0, v[23:0]});
    endfunction

    // High 24 bits of a signal as a signed operand
    function automatic mul_t hi_op(sig_t v);
        logic signed [23:0] h;
        h = v[47:24];
        return mul_t'(h);
    endfunction

endpackage

@@ design/hec_mac.sv @@
`timescale 1ns / 1ps

module hec_mac (
    input  logic            aclk,
    input  logic            aresetn,
    input  hec_pkg::mac_ctl_t ctl,
    input  hec_pkg::mul_t   op_a,
    input  hec_pkg::mul_t   op_b,
    output hec_pkg::acc_t   acc
);
    import hec_pkg::*;

    prod_t    prod_reg;
    mac_ctl_t ctl_reg;
    acc_t     acc_reg;
    acc_t     acc_next;
    acc_t     term;

    // Register the product
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl;
        end
    end

    // Align and accumulate the registered product
    always_comb begin
        unique case (ctl_reg.sh)
            SH_24:   term = acc_t'(prod_reg) <<< 24;
            SH_48:   term = acc_t'(prod_reg) <<< 48;
            default: term = acc_t'(prod_reg);
        endcase
        acc_next = (ctl_reg.clr ? acc_t'(0) : acc_reg) + term;
    end

    always_ff @(posedge aclk) begin
        if (ctl_reg.issue) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

@@ design/harmonic_exciter_biquad_chain.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Content
// s_axis    in         s_axis_tvalid / s_axis_tready  sample_in in tdata, channel in tuser
// m_axis    out        m_axis_tvalid / m_axis_tready  sample_out in tdata, channel_out in tuser
// cfg       in         cfg_valid / cfg_ready          register index and write data
//
// Each accepted sample is worked through in full before the next one is taken:
// 62 products through the single 33x33 multiply-accumulate unit, each group followed by
// a drain and a rounding step. Reset is synchronous, active low, and clears filter state
// through per-entry valid bits. A new sample is taken while a result still waits; the
// sequencer holds at its last step if the previous result has not been taken.

module harmonic_exciter_biquad_chain #(
    parameter int CHANNELS = 2,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // sample_in
    input  logic [0:0]                    s_axis_tuser,  // channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,  // sample_out
    output logic [0:0]                    m_axis_tuser,  // channel_out
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import hec_pkg::*;

    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DEPTH = CHANNELS * 4;
    localparam int AW = $clog2(DEPTH);
    localparam acc_t OUT_MAX = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - acc_t'(1);
    localparam acc_t OUT_MIN = -(acc_t'(1) <<< (SAMPLE_BITS - 1));

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DRY = 4'd1;
    localparam logic [3:0] ST_DRY_P = 4'd2;
    localparam logic [3:0] ST_SMUL = 4'd3;
    localparam logic [3:0] ST_SMUL_P = 4'd4;
    localparam logic [3:0] ST_BQ = 4'd5;
    localparam logic [3:0] ST_BQ_P = 4'd6;
    localparam logic [3:0] ST_WET = 4'd7;
    localparam logic [3:0] ST_BLEND = 4'd8;
    localparam logic [3:0] ST_BLEND_P = 4'd9;
    localparam logic [3:0] ST_OUT = 4'd10;
    localparam logic [3:0] ST_OUT_P = 4'd11;

    localparam logic [3:0] N_DRY = 4'd1;
    localparam logic [3:0] N_SMUL = 4'd4;
    localparam logic [3:0] N_BQ = 4'd10;
    localparam logic [3:0] N_BLEND = 4'd3;
    localparam logic [3:0] N_OUT = 4'd2;

    // Configuration registers
    logic [20:0]        input_gain_reg;
    logic [16:0]        mix_reg;
    logic [20:0]        output_volume_reg;
    logic [3:0]         harmonic_enable_reg;
    logic signed [31:0] coef_b0_reg, coef_b1_reg, coef_a1_reg, coef_a2_reg;

    // Sequencer and datapath registers
    logic [3:0]             state_reg, state_next;
    logic [3:0]             sub_reg, sub_next;
    logic [1:0]             harm_reg, harm_next;
    logic                   chbit_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    sig_t                   dry_reg, x_reg, blend_reg;
    sig_t                   h_reg [4];
    logic signed [25:0]     wet_reg;
    hist_t                  hist_mem [DEPTH];
    logic [DEPTH-1:0]       hist_vld_reg;
    hist_t                  hist_rd_reg;
    logic                   m_valid_reg;
    logic [DW-1:0]          m_data_reg;
    logic                   m_user_reg;

    mac_ctl_t mac_ctl;
    mul_t     mul_a, mul_b;
    acc_t     acc;

    logic           ch_idx;
    logic [AW-1:0]  hist_addr;
    sig_t           sm_a, sm_b;
    logic [47:0]    mag_a, mag_b;
    logic           sm_neg;
    logic [3:0]     n_ops;
    logic           in_mac;
    logic [16:0]    w_mix, d_mix;
    sig_t           dry_val, x_val, y_val, blend_val;
    acc_t           sm_mag, sm_lim, sm_sgn, x_scaled, wet_sum, o_val;
    logic [SAMPLE_BITS-1:0] o_bits;
    logic           out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;
    assign m_axis_tuser = m_user_reg;
    assign out_free = !m_valid_reg || m_axis_tready;

    // Filter state address from channel and harmonic
    assign ch_idx = (CHANNELS > 1) ? chbit_reg : 1'b0;
    assign hist_addr = AW'({ch_idx, harm_reg});

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_gain_reg <= RST_INPUT_GAIN;
            mix_reg <= RST_MIX;
            output_volume_reg <= RST_OUTPUT_VOLUME;
            harmonic_enable_reg <= RST_HARMONIC_ENABLE;
            coef_b0_reg <= RST_COEF_B0;
            coef_b1_reg <= RST_COEF_B1;
            coef_a1_reg <= RST_COEF_A1;
            coef_a2_reg <= RST_COEF_A2;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_INPUT_GAIN:      input_gain_reg <= cfg_data[20:0];
                REG_MIX:             mix_reg <= cfg_data[16:0];
                REG_OUTPUT_VOLUME:   output_volume_reg <= cfg_data[20:0];
                REG_HARMONIC_ENABLE: harmonic_enable_reg <= cfg_data[3:0];
                REG_COEF_B0:         coef_b0_reg <= cfg_data;
                REG_COEF_B1:         coef_b1_reg <= cfg_data;
                REG_COEF_A1:         coef_a1_reg <= cfg_data;
                default:             coef_a2_reg <= cfg_data;
            endcase
        end
    end

    // Harmonic product sources and their magnitudes
    always_comb begin
        sm_a = (harm_reg == 2'd0) ? dry_reg : ((harm_reg == 2'd3) ? h_reg[1] : h_reg[0]);
        sm_b = (harm_reg == 2'd0) ? dry_reg : ((harm_reg == 2'd1) ? h_reg[0] : h_reg[1]);
        mag_a = sm_a[47] ? 48'(-sm_a) : 48'(sm_a);
        mag_b = sm_b[47] ? 48'(-sm_b) : 48'(sm_b);
        sm_neg = sm_a[47] ^ sm_b[47];
        w_mix = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
        d_mix = MIX_ONE - w_mix;
    end

    // Select operands for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mac_ctl.sh = SH_0;
        n_ops = '0;
        in_mac = 1'b0;
        unique case (state_reg)
            ST_DRY: begin
                in_mac = 1'b1;
                n_ops = N_DRY;
                mul_a = mul_t'(sample_reg);
                mul_b = mul_t'({12'b0, input_gain_reg});
            end
            ST_SMUL: begin
                in_mac = 1'b1;
                n_ops = N_SMUL;
                mul_a = mul_t'({9'b0, sub_reg[0] ? mag_a[47:24] : mag_a[23:0]});
                mul_b = mul_t'({9'b0, sub_reg[1] ? mag_b[47:24] : mag_b[23:0]});
                mac_ctl.sh = (sub_reg[1:0] == 2'd3) ? SH_48 :
                             ((sub_reg[1:0] == 2'd0) ? SH_0 : SH_24);
            end
            ST_BQ: begin
                in_mac = 1'b1;
                n_ops = N_BQ;
                mac_ctl.sh = sub_reg[0] ? SH_24 : SH_0;
                unique case (sub_reg[3:1])
                    3'd0: begin
                        mul_a = sub_reg[0] ? hi_op(x_reg) : lo_op(x_reg);
                        mul_b = mul_t'(coef_b0_reg);
                    end
                    3'd1: begin
                        mul_a = sub_reg[0] ? hi_op(hist_rd_reg.x1) : lo_op(hist_rd_reg.x1);
                        mul_b = mul_t'(coef_b1_reg);
                    end
                    3'd2: begin
                        mul_a = sub_reg[0] ? hi_op(hist_rd_reg.x2) : lo_op(hist_rd_reg.x2);
                        mul_b = mul_t'(coef_b0_reg);
                    end
                    3'd3: begin
                        mul_a = sub_reg[0] ? hi_op(hist_rd_reg.y1) : lo_op(hist_rd_reg.y1);
                        mul_b = -mul_t'(coef_a1_reg);
                    end
                    default: begin
                        mul_a = sub_reg[0] ? hi_op(hist_rd_reg.y2) : lo_op(hist_rd_reg.y2);
                        mul_b = -mul_t'(coef_a2_reg);
                    end
                endcase
            end
            ST_BLEND: begin
                in_mac = 1'b1;
                n_ops = N_BLEND;
                mul_b = mul_t'({16'b0, d_mix});
                unique case (sub_reg[1:0])
                    2'd0: begin
                        mul_a = mul_t'(wet_reg);
                        mul_b = mul_t'({16'b0, w_mix});
                    end
                    2'd1: mul_a = lo_op(dry_reg);
                    default: begin
                        mul_a = hi_op(dry_reg);
                        mac_ctl.sh = SH_24;
                    end
                endcase
            end
            ST_OUT: begin
                in_mac = 1'b1;
                n_ops = N_OUT;
                mul_b = mul_t'({12'b0, output_volume_reg});
                mul_a = sub_reg[0] ? hi_op(blend_reg) : lo_op(blend_reg);
                mac_ctl.sh = sub_reg[0] ? SH_24 : SH_0;
            end
            default: ;
        endcase
        mac_ctl.issue = in_mac && (sub_reg < n_ops);
        mac_ctl.clr = (sub_reg == 4'd0);
    end

    hec_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .acc     (acc)
    );

    // Round and saturate the accumulated results
    always_comb begin
        dry_val = sat_sig(rnd_asr(acc, SAMPLE_BITS - 9));
        sm_mag = (acc + (acc_t'(1) <<< 23)) >>> 24;
        sm_lim = sm_neg ? (acc_t'(1) <<< 47) : SIG_MAX_A;
        if (sm_mag > sm_lim) begin
            sm_mag = sm_lim;
        end
        sm_sgn = sm_neg ? -sm_mag : sm_mag;
        unique case (harm_reg)
            2'd0:    x_scaled = sm_sgn * GAIN_H2;
            2'd1:    x_scaled = sm_sgn * GAIN_H4;
            2'd2:    x_scaled = sm_sgn * GAIN_H6;
            default: x_scaled = sm_sgn * GAIN_H8;
        endcase
        x_val = sat_sig(x_scaled);
        y_val = sat_sig(rnd_asr(acc, COEF_FRAC_BITS));
        wet_sum = (harmonic_enable_reg[0] ? acc_t'(h_reg[0]) : acc_t'(0))
                + (harmonic_enable_reg[1] ? acc_t'(h_reg[1]) : acc_t'(0))
                + (harmonic_enable_reg[2] ? acc_t'(h_reg[2]) : acc_t'(0))
                + (harmonic_enable_reg[3] ? acc_t'(h_reg[3]) : acc_t'(0));
        if (wet_sum > WET_LIM_A) begin
            wet_sum = WET_LIM_A;
        end else if (wet_sum < -WET_LIM_A) begin
            wet_sum = -WET_LIM_A;
        end
        blend_val = sat_sig(rnd_asr(acc, 16));
        o_val = rnd_asr(acc, 41 - SAMPLE_BITS);
        if (o_val > OUT_MAX) begin
            o_val = OUT_MAX;
        end else if (o_val < OUT_MIN) begin
            o_val = OUT_MIN;
        end
        o_bits = o_val[SAMPLE_BITS-1:0];
    end

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        sub_next = sub_reg;
        harm_next = harm_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_DRY;
                    sub_next = '0;
                end
            end
            ST_DRY, ST_SMUL, ST_BQ, ST_BLEND, ST_OUT: begin
                if (sub_reg == n_ops) begin
                    state_next = state_reg + 4'd1;
                    sub_next = '0;
                end else begin
                    sub_next = sub_reg + 4'd1;
                end
            end
            ST_DRY_P: begin
                state_next = ST_SMUL;
                harm_next = 2'd0;
            end
            ST_SMUL_P: state_next = ST_BQ;
            ST_BQ_P: begin
                if (harm_reg == 2'd3) begin
                    state_next = ST_WET;
                end else begin
                    state_next = ST_SMUL;
                    harm_next = harm_reg + 2'd1;
                end
            end
            ST_WET: state_next = ST_BLEND;
            ST_BLEND_P: state_next = ST_OUT;
            ST_OUT_P: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sub_reg <= '0;
            harm_reg <= '0;
        end else begin
            state_reg <= state_next;
            sub_reg <= sub_next;
            harm_reg <= harm_next;
        end
    end

    // Capture the input word and intermediate signals
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_axis_tvalid) begin
            chbit_reg <= s_axis_tuser[0];
            sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (state_reg == ST_DRY_P) begin
            dry_reg <= dry_val;
        end
        if (state_reg == ST_SMUL_P) begin
            x_reg <= x_val;
        end
        if (state_reg == ST_BQ_P) begin
            h_reg[harm_reg] <= y_val;
        end
        if (state_reg == ST_WET) begin
            wet_reg <= wet_sum[25:0];
        end
        if (state_reg == ST_BLEND_P) begin
            blend_reg <= blend_val;
        end
    end

    // Filter history memory: read during the harmonic product, write after the filter
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SMUL) begin
            hist_rd_reg <= hist_vld_reg[hist_addr] ? hist_mem[hist_addr] : '0;
        end
        if (state_reg == ST_BQ_P) begin
            hist_mem[hist_addr] <= '{x1: x_reg, x2: hist_rd_reg.x1,
                                     y1: y_val, y2: hist_rd_reg.y1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg <= '0;
        end else if (state_reg == ST_BQ_P) begin
            hist_vld_reg[hist_addr] <= 1'b1;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT_P && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT_P && out_free) begin
            m_data_reg <= DW'(o_bits);
            m_user_reg <= chbit_reg;
        end
    end

endmodule

@@ design/hec_checker.sv @@
`timescale 1ns / 1ps

module hec_checker #(
    parameter int DW = 24
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [DW-1:0] m_axis_tdata,
    input logic [0:0]    m_axis_tuser
);

    // Busy after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready stayed high after an accept");

    // No result straight after an accept when none was pending
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared one cycle after accept");

    // Reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

endmodule

bind harmonic_exciter_biquad_chain hec_checker #(
    .DW(((SAMPLE_BITS + 7) / 8) * 8)
) u_hec_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
